### rtl/assert_macros.svh
// Assertion macros shared by the descriptor index allocator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds on every clock edge outside reset
`define DIA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define DIA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/dia_pkg.sv
// Types and constants of the descriptor index allocator
`default_nettype none

package dia_pkg;

  localparam int IDX_W   = 10;
  localparam int CNT_W   = 11;
  localparam int ADDR_W  = 64;
  localparam int STRIDE_W = 16;
  localparam int CFG_W   = 64;
  localparam int CFG_IDX_W = 2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NO_SLOTS  = 2'd1;
  localparam logic [1:0] STAT_NONE_LIVE = 2'd2;
  localparam logic [1:0] STAT_LIST_FULL = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 2'd2;

  localparam logic [CNT_W-1:0]    RST_CAPACITY = 11'd1024;
  localparam logic [STRIDE_W-1:0] RST_STRIDE   = 16'd32;
  localparam logic [ADDR_W-1:0]   RST_BASE     = 64'd0;

  typedef struct packed {
    logic             func;
    logic [IDX_W-1:0] free_index;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]  slot_index;
    logic [ADDR_W-1:0] slot_address;
    logic [1:0]        status;
    logic [CNT_W-1:0]  live_count;
  } rsp_t;

endpackage

`default_nettype wire

### rtl/descriptor_index_allocator.sv
// Descriptor index allocator: bump allocator with a FIFO free list
//
//   channel  | signals                        | moves
//   ---------+--------------------------------+----------------------------------
//   request  | req_valid, req_ready, req      | one alloc or free per transfer
//   response | rsp_valid, rsp_ready, rsp      | one result per request
//   config   | cfg_we, cfg_index, cfg_data    | register write, no handshake
//
// One request is taken every cycle while the response side does not stall; each
// result is registered in the decision stage, then in the address multiply-add stage.
// The free list read is prefetched into a head register, so a pop does not wait
// for a memory read; a push into an empty list is forwarded into that register.
// Reset clears counters and pointers at once; the free list needs no clearing.
// A stalled response holds both stages and then the request side.
`default_nettype none

module descriptor_index_allocator
  import dia_pkg::*;
#(
  parameter int MAX_SLOTS = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_ready,
  input  wire req_t                 req,
  output logic                      rsp_valid,
  input  wire logic                 rsp_ready,
  output rsp_t                      rsp,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int PW = $clog2(MAX_SLOTS);
  localparam int FW = $clog2(MAX_SLOTS + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(MAX_SLOTS - 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(MAX_SLOTS);

  logic [CNT_W-1:0]    heap_capacity;
  logic [STRIDE_W-1:0] descriptor_stride;
  logic [ADDR_W-1:0]   cpu_base;

  logic [CNT_W-1:0] next_fresh, next_fresh_next;
  logic [PW-1:0]    fifo_head, fifo_head_next;
  logic [PW-1:0]    fifo_tail, fifo_tail_next;
  logic [FW-1:0]    fifo_fill, fifo_fill_next;
  logic [CNT_W-1:0] live_slots, live_slots_next;

  logic [IDX_W-1:0] fifo_mem [MAX_SLOTS];
  logic [IDX_W-1:0] head_data;

  logic             s1_valid;
  logic [IDX_W-1:0] s1_idx;
  logic [1:0]       s1_status;
  logic [CNT_W-1:0] s1_live;

  logic             transfer;
  logic             s1_adv;
  logic             s2_adv;
  logic             push;
  logic [CNT_W-1:0] cap_eff;
  logic [IDX_W-1:0] res_idx;
  logic [1:0]       res_status;
  logic [25:0]      offset;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + PW'(1);
  endfunction

  assign s2_adv    = !rsp_valid || rsp_ready;
  assign s1_adv    = !s1_valid || s2_adv;
  assign req_ready = s1_adv;
  assign transfer  = req_valid && req_ready;

  assign cap_eff = (32'(heap_capacity) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : heap_capacity;

  always_comb begin
    next_fresh_next = next_fresh;
    fifo_head_next  = fifo_head;
    fifo_tail_next  = fifo_tail;
    fifo_fill_next  = fifo_fill;
    live_slots_next = live_slots;
    res_idx         = '0;
    res_status      = STAT_OK;
    push            = 1'b0;
    if (transfer) begin
      if (req.func == FUNC_ALLOC) begin
        if (next_fresh < cap_eff) begin
          res_idx         = next_fresh[IDX_W-1:0];
          next_fresh_next = next_fresh + CNT_W'(1);
          live_slots_next = live_slots + CNT_W'(1);
        end else if (fifo_fill != '0) begin
          res_idx         = head_data;
          fifo_head_next  = ptr_inc(fifo_head);
          fifo_fill_next  = fifo_fill - FW'(1);
          live_slots_next = live_slots + CNT_W'(1);
        end else begin
          res_status = STAT_NO_SLOTS;
        end
      end else if (live_slots == '0) begin
        res_status = STAT_NONE_LIVE;
      end else if (fifo_fill == FILL_MAX) begin
        res_status = STAT_LIST_FULL;
      end else begin
        push            = 1'b1;
        fifo_tail_next  = ptr_inc(fifo_tail);
        fifo_fill_next  = fifo_fill + FW'(1);
        live_slots_next = live_slots - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_capacity     <= RST_CAPACITY;
      descriptor_stride <= RST_STRIDE;
      cpu_base          <= RST_BASE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CAPACITY: heap_capacity     <= cfg_data[CNT_W-1:0];
        CFG_STRIDE:   descriptor_stride <= cfg_data[STRIDE_W-1:0];
        CFG_BASE:     cpu_base          <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_fresh <= '0;
      fifo_head  <= '0;
      fifo_tail  <= '0;
      fifo_fill  <= '0;
      live_slots <= '0;
    end else begin
      next_fresh <= next_fresh_next;
      fifo_head  <= fifo_head_next;
      fifo_tail  <= fifo_tail_next;
      fifo_fill  <= fifo_fill_next;
      live_slots <= live_slots_next;
    end
  end

  // Free list storage; keep the entry at the next head in head_data
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[fifo_tail] <= req.free_index;
    end
    if (push && (fifo_tail == fifo_head_next)) begin
      head_data <= req.free_index;
    end else begin
      head_data <= fifo_mem[fifo_head_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= transfer;
    end
    if (s1_adv) begin
      s1_idx    <= res_idx;
      s1_status <= res_status;
      s1_live   <= live_slots_next;
    end
  end

  assign offset = 26'(s1_idx) * 26'(descriptor_stride);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s2_adv) begin
      rsp_valid <= s1_valid;
    end
    if (s2_adv) begin
      rsp.slot_index   <= s1_idx;
      rsp.slot_address <= cpu_base + 64'(offset);
      rsp.status       <= s1_status;
      rsp.live_count   <= s1_live;
    end
  end

`include "assert_macros.svh"

  `DIA_ASSERT(a_count_balance, (32'(live_slots) + 32'(fifo_fill)) == 32'(next_fresh), "live plus queued differs from indices handed out")
  `DIA_ASSERT(a_empty_ptrs, (fifo_fill != '0) || (fifo_head == fifo_tail), "empty free list with head and tail apart")
  `DIA_ASSERT(a_fill_bound, fifo_fill <= FILL_MAX, "free list fill beyond depth")
  `DIA_ASSERT_NEXT(a_fresh_step, transfer && (req.func == FUNC_ALLOC) && (next_fresh < cap_eff), next_fresh == ($past(next_fresh) + CNT_W'(1)), "fresh index did not advance")

endmodule

`default_nettype wire
